>>> hdl/utc_ts_pkg.sv
// Shared types and constants for the UTC timestamp text parser.
// Used by the scanner, the date checker, the core and its checker.
package utc_ts_pkg;

	localparam int unsigned POS_W = 5;
	localparam int unsigned YEAR_W = 14;
	localparam int unsigned FIELD_W = 7;

	localparam logic [POS_W-1:0] TS_LEN = 5'd20;
	localparam logic [POS_W-1:0] POS_LAST = 5'd19;
	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1970;

	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} src_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hours;
		logic [FIELD_W-1:0] minutes;
		logic [FIELD_W-1:0] seconds;
	} result_t;

	// Snapshot of the scanner state at the final byte of a string
	typedef struct packed {
		logic               short_str;
		logic               fmt_err;
		logic [YEAR_W-1:0]  year;
		logic [4:0]         year_mod25;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hours;
		logic [FIELD_W-1:0] minutes;
		logic [FIELD_W-1:0] seconds;
	} fin_t;

endpackage

>>> hdl/utc_ts_scan.sv
// Byte scanner: position counter, separator checks and decimal accumulators.
// Depends on utc_ts_pkg.
module utc_ts_scan
	import utc_ts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  src_item_t  item,
	output fin_t       fin
);

	logic [POS_W-1:0]   pos_q;
	logic               fmt_err_q;
	logic [YEAR_W-1:0]  year_q;
	logic [4:0]         yr25_q;
	logic [FIELD_W-1:0] month_q, day_q, hours_q, minutes_q, seconds_q;

	logic               digit;
	logic [3:0]         dval;
	logic               is_sep;
	logic [7:0]         want;
	logic               byte_err;

	function automatic logic [FIELD_W-1:0] push2(input logic [FIELD_W-1:0] acc,
		input logic [3:0] d);
		logic [FIELD_W+3:0] x;
		x = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{FIELD_W{1'b0}}, d};
		return x[FIELD_W-1:0];
	endfunction

	function automatic logic [YEAR_W-1:0] push4(input logic [YEAR_W-1:0] acc,
		input logic [3:0] d);
		logic [YEAR_W+3:0] x;
		x = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{YEAR_W{1'b0}}, d};
		return x[YEAR_W-1:0];
	endfunction

	// (r*10 + d) mod 25; quotient by reciprocal 41/1024, exact for x < 250
	function automatic logic [4:0] mod25_step(input logic [4:0] r, input logic [3:0] d);
		logic [7:0]  x;
		logic [13:0] prod;
		logic [3:0]  q;
		logic [7:0]  qm;
		x = ({3'b0, r} << 3) + ({3'b0, r} << 1) + {4'b0, d};
		prod = {6'b0, x} * 14'd41;
		q = prod[13:10];
		qm = ({4'b0, q} << 4) + ({4'b0, q} << 3) + {4'b0, q};
		return 5'(x - qm);
	endfunction

	always_comb begin
		digit = (item.char_byte >= CH_ZERO) && (item.char_byte <= CH_NINE);
		dval = digit ? item.char_byte[3:0] : 4'd0;
		is_sep = 1'b1;
		want = CH_DASH;
		case (pos_q)
			5'd4, 5'd7: want = CH_DASH;
			5'd10: want = CH_T;
			5'd13, 5'd16: want = CH_COLON;
			5'd19: want = CH_Z;
			default: is_sep = 1'b0;
		endcase
		byte_err = is_sep ? (item.char_byte != want) : !digit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fmt_err_q <= 1'b0;
			year_q <= '0;
			yr25_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hours_q <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
		end else if (take) begin
			if (item.last_char) begin
				pos_q <= '0;
				fmt_err_q <= 1'b0;
				year_q <= '0;
				yr25_q <= '0;
				month_q <= '0;
				day_q <= '0;
				hours_q <= '0;
				minutes_q <= '0;
				seconds_q <= '0;
			end else if (pos_q < TS_LEN) begin
				pos_q <= pos_q + 5'd1;
				if (byte_err)
					fmt_err_q <= 1'b1;
				if (!is_sep) begin
					if (pos_q <= 5'd3) begin
						year_q <= push4(year_q, dval);
						yr25_q <= mod25_step(yr25_q, dval);
					end else if (pos_q <= 5'd6)
						month_q <= push2(month_q, dval);
					else if (pos_q <= 5'd9)
						day_q <= push2(day_q, dval);
					else if (pos_q <= 5'd12)
						hours_q <= push2(hours_q, dval);
					else if (pos_q <= 5'd15)
						minutes_q <= push2(minutes_q, dval);
					else
						seconds_q <= push2(seconds_q, dval);
				end
			end
		end
	end

	// A full-length string: the final byte is either 'Z' or past the end, so the
	// accumulators already hold their final values; only the 'Z' check adds in.
	always_comb begin
		fin.short_str = pos_q < POS_LAST;
		fin.fmt_err = fmt_err_q || ((pos_q == POS_LAST) && byte_err);
		fin.year = year_q;
		fin.year_mod25 = yr25_q;
		fin.month = month_q;
		fin.day = day_q;
		fin.hours = hours_q;
		fin.minutes = minutes_q;
		fin.seconds = seconds_q;
	end

endmodule

>>> hdl/utc_ts_check.sv
// Calendar check: builds the result from the scanner snapshot.
// Depends on utc_ts_pkg.
module utc_ts_check
	import utc_ts_pkg::*;
(
	input  fin_t    fin,
	output result_t res
);

	logic       leap;
	logic [4:0] max_day;
	logic       month_ok;
	logic       date_ok;

	always_comb begin
		// 4 | y, and 100 does not divide y unless 400 does
		leap = (fin.year[1:0] == 2'd0) &&
			((fin.year_mod25 != 5'd0) || (fin.year[3:0] == 4'd0));
		month_ok = 1'b1;
		case (fin.month)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: max_day = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11: max_day = 5'd30;
			7'd2: max_day = leap ? 5'd29 : 5'd28;
			default: begin
				max_day = 5'd0;
				month_ok = 1'b0;
			end
		endcase
		date_ok = !fin.fmt_err && month_ok && (fin.year >= EPOCH_YEAR) &&
			(fin.day >= 7'd1) && (fin.day <= {2'b0, max_day}) &&
			(fin.hours < 7'd24) && (fin.minutes < 7'd60) && (fin.seconds < 7'd60);

		if (fin.short_str) begin
			res = '0;
			res.status = ST_SHORT;
		end else begin
			res.status = date_ok ? ST_OK : ST_INVALID;
			res.year = fin.year;
			res.month = fin.month;
			res.day = fin.day;
			res.hours = fin.hours;
			res.minutes = fin.minutes;
			res.seconds = fin.seconds;
		end
	end

endmodule

>>> hdl/utc_timestamp_text_parser_core.sv
// UTC timestamp parser core: one text byte per cycle, result on the final byte.
// Result: held in the output entry, or in the skid entry if that one is full.
// Throughput: one byte per cycle; a two-entry result buffer stalls input only
// when both entries hold results not yet taken.
// Reset: arst_n clears position, error flag, accumulators and buffer state.
module utc_timestamp_text_parser_core
	import utc_ts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_data,
	output logic      res_valid,
	input  logic      res_stall,
	output result_t   res_data
);

	logic    take;
	logic    push;
	logic    pop;
	fin_t    fin;
	result_t res_new;

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	assign src_stall = skid_valid_q;
	assign take = src_valid && !src_stall;
	assign push = take && src_data.last_char;
	assign pop = out_valid_q && !res_stall;

	utc_ts_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (src_data),
		.fin    (fin)
	);

	utc_ts_check u_check (
		.fin (fin),
		.res (res_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_q <= res_new;
			else
				skid_q <= res_new;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data = out_q;

endmodule

>>> hdl/utc_ts_chk.sv
// Port checker for the UTC timestamp parser core, bound to the top level.
// Depends on utc_ts_pkg.
module utc_ts_chk
	import utc_ts_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      src_valid,
	input logic      src_stall,
	input src_item_t src_data,
	input logic      res_valid,
	input logic      res_stall,
	input result_t   res_data
);

	// a stalled result transaction holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// a new result only follows a final-byte transaction
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(src_valid && !src_stall && src_data.last_char))
		else $error("result without final byte");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == ST_OK) |->
			(res_data.year >= EPOCH_YEAR) && (res_data.month >= 7'd1) &&
			(res_data.month <= 7'd12) && (res_data.day >= 7'd1) &&
			(res_data.day <= 7'd31) && (res_data.hours < 7'd24) &&
			(res_data.minutes < 7'd60) && (res_data.seconds < 7'd60))
		else $error("ok status with out-of-range field");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == ST_SHORT) |->
			(res_data.year == '0) && (res_data.month == '0) && (res_data.day == '0) &&
			(res_data.hours == '0) && (res_data.minutes == '0) &&
			(res_data.seconds == '0))
		else $error("short string with nonzero fields");

endmodule

bind utc_timestamp_text_parser_core utc_ts_chk u_utc_ts_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_data  (src_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

>>> tb/utc_timestamp_text_parser_core_test.sv
// Self-checking bench for utc_timestamp_text_parser_core: timestamp text is fed byte by byte,
// and each result is checked against a cycle-free predictor of the scanner and date checks.
// Depends on utc_ts_pkg for the payload structs, status codes and character constants.
module utc_timestamp_text_parser_core_test;
	import utc_ts_pkg::*;

	typedef enum int {PH_STEADY, PH_SRC_GAPS, PH_SNK_STALLS, PH_BOTH} phase_e;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTES_PER_PHASE = 425;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	src_item_t src_data = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	result_t   res_data;

	src_item_t text_q[$];
	result_t   stamp_q[$];
	phase_e    phase = PH_STEADY;
	int        pushed = 0;
	int        fails = 0;
	int        cycles = 0;

	// predictor state
	logic [POS_W-1:0]   scan_pos = '0;
	logic               bad_fmt = 1'b0;
	logic [YEAR_W-1:0]  acc_year = '0;
	logic [FIELD_W-1:0] acc_month = '0;
	logic [FIELD_W-1:0] acc_day = '0;
	logic [FIELD_W-1:0] acc_hours = '0;
	logic [FIELD_W-1:0] acc_minutes = '0;
	logic [FIELD_W-1:0] acc_seconds = '0;

	utc_timestamp_text_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	initial forever #4 clk = ~clk;

	function automatic int idle_pct(phase_e p, bit sink);
		if (p == PH_BOTH)
			return 24;
		if ((p == PH_SRC_GAPS && !sink) || (p == PH_SNK_STALLS && sink))
			return 76;
		return 0;
	endfunction

	function automatic bit feb_has_29(int y);
		if (y % 4 != 0)
			return 1'b0;
		if (y % 100 != 0)
			return 1'b1;
		return (y % 400) == 0;
	endfunction

	function automatic bit calendar_ok();
		int maxd;
		if (acc_year < EPOCH_YEAR)
			return 1'b0;
		case (acc_month)
			1, 3, 5, 7, 8, 10, 12: maxd = 31;
			4, 6, 9, 11: maxd = 30;
			2: maxd = feb_has_29(acc_year) ? 29 : 28;
			default: maxd = 0;
		endcase
		if (maxd == 0 || acc_day < 1 || acc_day > maxd)
			return 1'b0;
		return acc_hours < 24 && acc_minutes < 60 && acc_seconds < 60;
	endfunction

	// Advance the scanner by one accepted byte; queue the parsed stamp on the final byte.
	task automatic scan_char(src_item_t it);
		logic [7:0]  c;
		logic [7:0]  sep;
		bit          is_digit;
		int unsigned d;
		result_t     r;
		c = it.char_byte;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = is_digit ? int'(c - CH_ZERO) : 0;
		if (scan_pos < TS_LEN) begin
			case (scan_pos)
				4, 7: sep = CH_DASH;
				10: sep = CH_T;
				13, 16: sep = CH_COLON;
				POS_LAST: sep = CH_Z;
				default: sep = 8'h00;
			endcase
			if (sep != 8'h00) begin
				if (c != sep)
					bad_fmt = 1'b1;
			end else begin
				if (!is_digit)
					bad_fmt = 1'b1;
				if (scan_pos <= 3)
					acc_year = YEAR_W'(acc_year * 10 + d);
				else if (scan_pos <= 6)
					acc_month = FIELD_W'(acc_month * 10 + d);
				else if (scan_pos <= 9)
					acc_day = FIELD_W'(acc_day * 10 + d);
				else if (scan_pos <= 12)
					acc_hours = FIELD_W'(acc_hours * 10 + d);
				else if (scan_pos <= 15)
					acc_minutes = FIELD_W'(acc_minutes * 10 + d);
				else
					acc_seconds = FIELD_W'(acc_seconds * 10 + d);
			end
			scan_pos = scan_pos + 1'b1;
		end
		if (it.last_char) begin
			r = '0;
			if (scan_pos < TS_LEN) begin
				r.status = ST_SHORT;
			end else begin
				r.status = (!bad_fmt && calendar_ok()) ? ST_OK : ST_INVALID;
				r.year = acc_year;
				r.month = acc_month;
				r.day = acc_day;
				r.hours = acc_hours;
				r.minutes = acc_minutes;
				r.seconds = acc_seconds;
			end
			stamp_q.push_back(r);
			scan_pos = '0;
			bad_fmt = 1'b0;
			acc_year = '0;
			acc_month = '0;
			acc_day = '0;
			acc_hours = '0;
			acc_minutes = '0;
			acc_seconds = '0;
		end
	endtask

	task automatic add_char(logic [7:0] c, bit mark);
		src_item_t it;
		it.char_byte = c;
		it.last_char = mark;
		text_q.push_back(it);
		pushed++;
	endtask

	task automatic add_text(string s, bit mark);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], mark && i == s.len() - 1);
	endtask

	// Mostly well-formed stamps with random content, some broken or cut short, some noise.
	task automatic gen_stamp();
		int         kind;
		int         len;
		int         bad_pos;
		int         extra;
		int         y, mo, d, h, mi, se;
		bit         mark;
		string      s;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			len = $urandom_range(1, 26);
			for (int i = 0; i < len; i++)
				add_char(8'($urandom_range(0, 255)), i == len - 1);
			return;
		end
		case ($urandom_range(0, 5))
			0: y = $urandom_range(0, 9999);
			1: begin
				case ($urandom_range(0, 5))
					0: y = 1900;
					1: y = 2000;
					2: y = 2100;
					3: y = 2400;
					4: y = 1969;
					default: y = 1970;
				endcase
			end
			default: y = $urandom_range(1970, 2105);
		endcase
		mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
		case ($urandom_range(0, 9))
			0: d = $urandom_range(0, 99);
			1, 2, 3: d = $urandom_range(28, 31);
			default: d = $urandom_range(1, 31);
		endcase
		h = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
		mi = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
		se = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
		s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", y, mo, d, h, mi, se);
		len = 20;
		bad_pos = -1;
		extra = 0;
		mark = 1'b1;
		kind = $urandom_range(0, 99);
		if (kind < 12)
			len = $urandom_range(1, 19);
		else if (kind < 32)
			bad_pos = $urandom_range(0, 19);
		else if (kind < 45)
			extra = $urandom_range(1, 6);
		else if (kind < 50)
			mark = 1'b0;
		for (int i = 0; i < len; i++) begin
			c = (i == bad_pos) ? 8'($urandom_range(0, 255)) : s[i];
			add_char(c, mark && extra == 0 && i == len - 1);
		end
		for (int i = 0; i < extra; i++)
			add_char(8'($urandom_range(0, 255)), i == extra - 1);
	endtask

	// Hold off the sender until every byte is taken and every stamp has come back.
	task automatic drain();
		do
			@(posedge clk);
		while (text_q.size() != 0 || src_valid || stamp_q.size() != 0);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data <= '0;
		end else begin
			if (src_valid && !src_stall)
				scan_char(src_data);
			if (!src_valid || !src_stall) begin
				if (text_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(phase, 1'b0)) begin
					src_valid <= 1'b1;
					src_data <= text_q.pop_front();
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (stamp_q.size() == 0) begin
					$display("%0t: expected no transaction, actual %p", $time, res_data);
					fails++;
				end else begin
					check_field("status", stamp_q[0].status, res_data.status);
					check_field("year", stamp_q[0].year, res_data.year);
					check_field("month", stamp_q[0].month, res_data.month);
					check_field("day", stamp_q[0].day, res_data.day);
					check_field("hours", stamp_q[0].hours, res_data.hours);
					check_field("minutes", stamp_q[0].minutes, res_data.minutes);
					check_field("seconds", stamp_q[0].seconds, res_data.seconds);
					void'(stamp_q.pop_front());
				end
			end
			res_stall <= ($urandom_range(0, 99) < idle_pct(phase, 1'b1));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("utc_timestamp_text_parser_core: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// extremes, trailing byte ignored past the twentieth
		add_text("9999-12-31T23:59:59Z", 1'b0);
		add_char(8'hFF, 1'b1);
		add_text("1970-01-01T00:00:00Z", 1'b1);
		add_char(8'h00, 1'b1);
		add_text("2000-02-29T12:30:45Z", 1'b1);
		add_text("2024-06-1xT10:20:30Z", 1'b1);
		add_text("2024/06-15T10:20:30Z", 1'b1);
		// string split over two runs, only the second one marked
		add_text("1999", 1'b0);
		add_text("-12-31T23:59:59Z", 1'b1);
		drain();
		for (int p = PH_STEADY; p <= PH_BOTH; p++) begin
			@(negedge clk);
			phase = phase_e'(p);
			while (pushed < (p + 1) * BYTES_PER_PHASE)
				gen_stamp();
			drain();
		end
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("utc_timestamp_text_parser_core: match");
		else
			$display("utc_timestamp_text_parser_core: mismatch");
		$finish;
	end

endmodule
